// ===== src/decimal_text_to_integer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text to integer unit
// Shared concurrent-check forms used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_INTEGER_UNIT_DEFINES_SVH
`define DECIMAL_TEXT_TO_INTEGER_UNIT_DEFINES_SVH

// same-cycle implication
`define DTOI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTOI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dtoi_pkg.sv =====
// ----------------------------------------------------------------------------
// dtoi_pkg
// Types and constants of the decimal text to integer unit.
// ----------------------------------------------------------------------------
package dtoi_pkg;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_SIGNED = 2'd1,
    PH_DIGITS = 2'd2,
    PH_JUNK   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_UNDERFLOW  = 2'd2,
    ST_INCONVERT  = 2'd3
  } status_t;

  localparam logic [63:0] MAG_CAP     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX_64  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] POS_MAX_32  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_MAX_32  = 64'h0000_0000_8000_0000;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  typedef struct packed {
    logic       is_term;
    logic       is_space;
    logic       is_sign;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
  } byte_class_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] value;
  } result_t;

endpackage

// ===== src/dtoi_classify.sv =====
// ----------------------------------------------------------------------------
// dtoi_classify
// Sorts one text byte into terminator, whitespace, sign, digit or other.
// ----------------------------------------------------------------------------
module dtoi_classify
  import dtoi_pkg::*;
(
  input  logic [7:0]  text_byte,
  output byte_class_t cls
);

  logic [7:0] digit_full;

  assign digit_full = text_byte - CH_ZERO;

  always_comb begin
    cls.is_term  = (text_byte == CH_NUL);
    cls.is_space = (text_byte == CH_SPACE) || (text_byte inside {[CH_TAB:CH_CR]});
    cls.is_sign  = (text_byte == CH_PLUS) || (text_byte == CH_MINUS);
    cls.is_minus = (text_byte == CH_MINUS);
    cls.is_digit = text_byte inside {[CH_ZERO:CH_NINE]};
    cls.digit    = digit_full[3:0];
  end

endmodule

// ===== src/dtoi_scan.sv =====
// ----------------------------------------------------------------------------
// dtoi_scan
// Scan state and saturating decimal accumulator; forms the result at the
// terminator and clears itself for the next text.
// ----------------------------------------------------------------------------
`include "decimal_text_to_integer_unit_defines.svh"

module dtoi_scan
  import dtoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wide_mode,
  input  logic        step,
  input  byte_class_t cls,
  output result_t     res
);

  phase_t      phase, phase_next;
  logic        is_negative, is_negative_next;
  logic [63:0] magnitude, magnitude_next;
  logic        range_exceeded, range_exceeded_next;
  logic        digit_seen, digit_seen_next;
  logic        trailing_junk, trailing_junk_next;

  logic [67:0] mag_x10_sum;
  logic        sum_exceeds;
  logic [63:0] pos_max, neg_max;

  // magnitude * 10 + digit, checked against the cap
  assign mag_x10_sum = ({4'd0, magnitude} << 3) + ({4'd0, magnitude} << 1)
                     + {64'd0, cls.digit};
  assign sum_exceeds = mag_x10_sum > {4'd0, MAG_CAP};

  always_comb begin
    phase_next          = phase;
    is_negative_next    = is_negative;
    magnitude_next      = magnitude;
    range_exceeded_next = range_exceeded;
    digit_seen_next     = digit_seen;
    trailing_junk_next  = trailing_junk;
    if (step) begin
      if (cls.is_term) begin
        phase_next          = PH_LEAD;
        is_negative_next    = 1'b0;
        magnitude_next      = '0;
        range_exceeded_next = 1'b0;
        digit_seen_next     = 1'b0;
        trailing_junk_next  = 1'b0;
      end else begin
        case (phase)
          PH_LEAD, PH_SIGNED, PH_DIGITS: begin
            if (cls.is_digit) begin
              digit_seen_next = 1'b1;
              phase_next      = PH_DIGITS;
              if (!range_exceeded) begin
                if (sum_exceeds) begin
                  range_exceeded_next = 1'b1;
                  magnitude_next      = MAG_CAP;
                end else begin
                  magnitude_next = mag_x10_sum[63:0];
                end
              end
            end else if (phase == PH_LEAD && cls.is_space) begin
              phase_next = PH_LEAD;
            end else if (phase == PH_LEAD && cls.is_sign) begin
              is_negative_next = cls.is_minus;
              phase_next       = PH_SIGNED;
            end else begin
              trailing_junk_next = 1'b1;
              phase_next         = PH_JUNK;
            end
          end
          default: begin
            trailing_junk_next = 1'b1;
          end
        endcase
      end
    end
  end

  always_comb begin
    pos_max   = wide_mode ? POS_MAX_64 : POS_MAX_32;
    neg_max   = wide_mode ? MAG_CAP : NEG_MAX_32;
    res.value = '0;
    if (digit_seen && !is_negative && (range_exceeded || magnitude > pos_max)) begin
      res.status = ST_OVERFLOW;
    end else if (digit_seen && is_negative && (range_exceeded || magnitude > neg_max)) begin
      res.status = ST_UNDERFLOW;
    end else if (!digit_seen || trailing_junk) begin
      res.status = ST_INCONVERT;
    end else begin
      res.status = ST_OK;
      res.value  = is_negative ? (64'd0 - magnitude) : magnitude;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_LEAD;
      is_negative    <= 1'b0;
      magnitude      <= '0;
      range_exceeded <= 1'b0;
      digit_seen     <= 1'b0;
      trailing_junk  <= 1'b0;
    end else begin
      phase          <= phase_next;
      is_negative    <= is_negative_next;
      magnitude      <= magnitude_next;
      range_exceeded <= range_exceeded_next;
      digit_seen     <= digit_seen_next;
      trailing_junk  <= trailing_junk_next;
    end
  end

  `DTOI_ASSERT_IMP(a_cap_held, clk, rst, range_exceeded, magnitude == MAG_CAP, "saturated magnitude not at cap")
  `DTOI_ASSERT_IMP(a_junk_flag, clk, rst, phase == PH_JUNK, trailing_junk, "junk phase without junk flag")
  `DTOI_ASSERT_NXT(a_clear_after_term, clk, rst, step && cls.is_term, (phase == PH_LEAD) && !digit_seen && !trailing_junk, "scan state not cleared after terminator")

endmodule

// ===== src/dtoi_out_reg.sv =====
// ----------------------------------------------------------------------------
// dtoi_out_reg
// Result register; takes a new result when empty or while the held one is being taken.
// ----------------------------------------------------------------------------
module dtoi_out_reg
  import dtoi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_res,
  output logic    can_load,
  output logic    valid,
  input  logic    ready,
  output result_t res
);

  assign can_load = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res <= load_res;
    end
  end

endmodule

// ===== src/decimal_text_to_integer_unit.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_integer_unit
// Base-10 text to signed integer converter, one text byte per item.
//
//   channel  direction  payload
//   s_*      in         text byte, zero ends the text
//   m_*      out        status and value, one item per terminator
//   cfg_*    in         wide_mode (0: 32-bit range, 1: 64-bit range)
//
// One byte per cycle sustained while no terminator waits on a stalled result;
// a terminator is registered in the input byte register and its result in
// the output register. The per-byte path is the multiply-by-ten-and-add of
// the 64-bit accumulator. Synchronous reset clears the scan state and
// selects the 32-bit range. A stalled result holds back the next terminator
// and the bytes behind it; bytes before it keep flowing.
// ----------------------------------------------------------------------------
`include "decimal_text_to_integer_unit_defines.svh"

module decimal_text_to_integer_unit
  import dtoi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [1:0] status, [65:2] parsed_value, [71:66] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  logic        wide_mode;
  logic        in_valid;
  logic [7:0]  in_byte;
  byte_class_t cls;
  logic        advance;
  logic        step;
  logic        can_load;
  result_t     scan_res;
  result_t     out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      wide_mode <= cfg_data;
    end
  end

  dtoi_classify u_classify (
    .text_byte (in_byte),
    .cls       (cls)
  );

  // a terminator waits for room in the result register
  assign advance  = !cls.is_term || can_load;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  dtoi_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .wide_mode (wide_mode),
    .step      (step),
    .cls       (cls),
    .res       (scan_res)
  );

  dtoi_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (step && cls.is_term),
    .load_res (scan_res),
    .can_load (can_load),
    .valid    (m_tvalid),
    .ready    (m_tready),
    .res      (out_res)
  );

  assign m_tdata = {6'd0, out_res.value, out_res.status};

  `DTOI_ASSERT_IMP(a_bad_status_zero, clk, rst, m_tvalid && (m_tdata[1:0] != ST_OK), m_tdata[65:2] == 64'd0, "non-ok result with nonzero value")
  `DTOI_ASSERT_IMP(a_narrow_fits, clk, rst, m_tvalid && (m_tdata[1:0] == ST_OK) && !wide_mode, (&m_tdata[65:33]) || (m_tdata[65:33] == 33'd0), "ok value outside 32-bit range")
  `DTOI_ASSERT_IMP(a_term_backpressure, clk, rst, in_valid && cls.is_term && m_tvalid && !m_tready, !s_tready && !step, "terminator taken while result stalled")

endmodule
